>>> src/bst_pkg.sv
`default_nettype none
package bst_pkg;
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_W = 32;
   localparam int SRC_W = 48;
   localparam int WORD_W = 1 + KEY_W + SRC_W;
   localparam logic [7:0] SESSION_LIMIT = 8'd127;

   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_KEY_BY_SRC = 2'd2;
   localparam logic [1:0] REQ_SRC_BY_KEY = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [WORD_W-1:0] word_type;
endpackage
`default_nettype wire

>>> src/bidirectional_session_table_top.sv
`default_nettype none
// each table search walks the memory one entry per cycle through its single read port
// throughput: one word at a time, start is taken again in the cycle rsp_valid shows
// reset: synchronous; afterwards a clearing pass over both tables holds busy high
// the result is a one-cycle strobe, the receiver cannot stall it
module bidirectional_session_table_top
   import bst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [15:0] req_src_port,
   input  wire logic [31:0] req_key_in,
   input  wire logic [7:0]  req_session_num,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_key_out,
   output logic [31:0]      rsp_addr_out,
   output logic [15:0]      rsp_port_out
);
   // sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_C1    = 4'd3;
   localparam logic [3:0] S_C2    = 4'd4;
   localparam logic [3:0] S_C3    = 4'd5;
   localparam logic [3:0] S_D1    = 4'd6;
   localparam logic [3:0] S_D2    = 4'd7;
   localparam logic [3:0] S_LK    = 4'd8;
   localparam logic [3:0] S_LS    = 4'd9;

   // word layouts: forward {valid, key, source}, reverse {valid, source, key}
   word_type fwd_mem [TABLE_ENTRIES];
   word_type rev_mem [TABLE_ENTRIES];
   word_type fwd_rd_ff, rev_rd_ff;
   logic     fwd_we, rev_we;
   idx_type  fwd_wa, rev_wa, rd_addr;
   word_type fwd_wd, rev_wd;

   logic [3:0]       state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pv_ff, pv_in;
   idx_type          pidx_ff, pidx_in;
   logic             sel_rev_ff, sel_rev_in;
   logic [KEY_W-1:0] kcmp_ff, kcmp_in;
   logic [SRC_W-1:0] scmp_ff, scmp_in;
   logic             hit_ff, hit_in, frf_ff, frf_in;
   idx_type          hidx_ff, hidx_in, fidx_ff, fidx_in, save_ff, save_in;
   word_type         hword_ff, hword_in;
   logic [1:0]       op_ff, op_in;
   logic [SRC_W-1:0] src_ff, src_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             sess_ff, sess_in, full_ff, full_in;
   logic             rv_ff, rv_in;
   logic [1:0]       rs_ff, rs_in;
   logic [31:0]      rk_ff, rk_in, ra_ff, ra_in;
   logic [15:0]      rp_ff, rp_in;

   // scan launch request
   logic             go, go_rev;
   logic [3:0]       go_ret;
   logic [KEY_W-1:0] go_key;
   logic [SRC_W-1:0] go_src;

   word_type scan_word;
   logic     scan_vld, scan_match;

   // memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[fwd_wa] <= fwd_wd;
      end
      if (rev_we) begin
         rev_mem[rev_wa] <= rev_wd;
      end
      fwd_rd_ff <= fwd_mem[rd_addr];
      rev_rd_ff <= rev_mem[rd_addr];
   end

   assign rd_addr    = cnt_ff[IDX_W-1:0];
   assign scan_word  = sel_rev_ff ? rev_rd_ff : fwd_rd_ff;
   assign scan_vld   = scan_word[WORD_W-1];
   assign scan_match = scan_vld && (sel_rev_ff ? (scan_word[WORD_W-2 -: SRC_W] == scmp_ff)
                                              : (scan_word[WORD_W-2 -: KEY_W] == kcmp_ff));

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;    cnt_in = cnt_ff;
      pv_in = 1'b0;         pidx_in = pidx_ff;  sel_rev_in = sel_rev_ff;
      kcmp_in = kcmp_ff;    scmp_in = scmp_ff;  hit_in = hit_ff;
      hidx_in = hidx_ff;    hword_in = hword_ff;
      frf_in = frf_ff;      fidx_in = fidx_ff;  save_in = save_ff;
      op_in = op_ff;        src_in = src_ff;    key_in = key_ff;
      sess_in = sess_ff;    full_in = full_ff;
      rv_in = 1'b0;         rs_in = rs_ff;      rk_in = rk_ff;
      ra_in = ra_ff;        rp_in = rp_ff;
      fwd_we = 1'b0;        fwd_wa = hidx_ff;   fwd_wd = '0;
      rev_we = 1'b0;        rev_wa = hidx_ff;   rev_wd = '0;
      go = 1'b0;            go_rev = 1'b0;      go_ret = S_IDLE;
      go_key = key_ff;      go_src = src_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // wipe valid bits of both tables
            fwd_we = 1'b1;  fwd_wa = cnt_ff[IDX_W-1:0];
            rev_we = 1'b1;  rev_wa = cnt_ff[IDX_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in   = req_type;
               src_in  = {req_src_addr, req_src_port};
               key_in  = req_key_in;
               sess_in = (req_session_num > SESSION_LIMIT);
               full_in = 1'b0;
               go      = 1'b1;
               go_key  = req_key_in;
               go_src  = {req_src_addr, req_src_port};
               case (req_type)
                  REQ_CREATE:     begin go_rev = 1'b0; go_ret = S_C1; end
                  REQ_DELETE:     begin go_rev = 1'b1; go_ret = S_D1; end
                  REQ_KEY_BY_SRC: begin go_rev = 1'b1; go_ret = S_LK; end
                  default:        begin go_rev = 1'b0; go_ret = S_LS; end
               endcase
            end
         end
         S_SCAN: begin
            // issue one read per cycle, compare the word that returns
            if (cnt_ff != CNT_W'(TABLE_ENTRIES)) begin
               pv_in   = 1'b1;
               pidx_in = cnt_ff[IDX_W-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
            if (pv_ff) begin
               if (scan_match) begin
                  hit_in   = 1'b1;
                  hidx_in  = pidx_ff;
                  hword_in = scan_word;
               end
               if (!scan_vld && !frf_ff) begin
                  frf_in  = 1'b1;
                  fidx_in = pidx_ff;
               end
            end else if (cnt_ff == CNT_W'(TABLE_ENTRIES)) begin
               state_in = ret_ff;
            end
         end
         S_C1: begin
            if (hit_ff) begin
               // drop the reverse entry of the old source first
               save_in = hidx_ff;
               go = 1'b1;  go_rev = 1'b1;  go_ret = S_C2;
               go_src = hword_ff[SRC_W-1:0];
            end else begin
               if (frf_ff) begin
                  fwd_we = 1'b1;  fwd_wa = fidx_ff;  fwd_wd = {1'b1, key_ff, src_ff};
               end else begin
                  full_in = 1'b1;
               end
               if (sess_ff) begin
                  go = 1'b1;  go_rev = 1'b1;  go_ret = S_C3;
               end else begin
                  state_in = S_IDLE;  rv_in = 1'b1;
                  rs_in = frf_ff ? ST_OK : ST_FULL;
                  rk_in = '0;  ra_in = '0;  rp_in = '0;
               end
            end
         end
         S_C2: begin
            if (hit_ff) begin
               rev_we = 1'b1;  rev_wa = hidx_ff;
               rev_wd = {1'b0, hword_ff[WORD_W-2:0]};
            end
            fwd_we = 1'b1;  fwd_wa = save_ff;  fwd_wd = {1'b1, key_ff, src_ff};
            if (sess_ff) begin
               go = 1'b1;  go_rev = 1'b1;  go_ret = S_C3;
            end else begin
               state_in = S_IDLE;  rv_in = 1'b1;  rs_in = ST_OK;
               rk_in = '0;  ra_in = '0;  rp_in = '0;
            end
         end
         S_C3: begin
            // set or insert the source-to-key entry
            rev_wd = {1'b1, src_ff, key_ff};
            if (hit_ff) begin
               rev_we = 1'b1;  rev_wa = hidx_ff;
            end else if (frf_ff) begin
               rev_we = 1'b1;  rev_wa = fidx_ff;
            end
            state_in = S_IDLE;  rv_in = 1'b1;
            rs_in = (full_ff || (!hit_ff && !frf_ff)) ? ST_FULL : ST_OK;
            rk_in = '0;  ra_in = '0;  rp_in = '0;
         end
         S_D1: begin
            if (hit_ff) begin
               save_in = hidx_ff;
               go = 1'b1;  go_rev = 1'b0;  go_ret = S_D2;
               go_key = hword_ff[KEY_W-1:0];
            end else begin
               state_in = S_IDLE;  rv_in = 1'b1;  rs_in = ST_MISS;
               rk_in = '0;  ra_in = '0;  rp_in = '0;
            end
         end
         S_D2: begin
            if (hit_ff) begin
               fwd_we = 1'b1;  fwd_wa = hidx_ff;
               fwd_wd = {1'b0, hword_ff[WORD_W-2:0]};
            end
            rev_we = 1'b1;  rev_wa = save_ff;  rev_wd = '0;
            state_in = S_IDLE;  rv_in = 1'b1;  rs_in = ST_OK;
            rk_in = '0;  ra_in = '0;  rp_in = '0;
         end
         S_LK: begin
            state_in = S_IDLE;  rv_in = 1'b1;
            rs_in = hit_ff ? ST_OK : ST_MISS;
            rk_in = hit_ff ? hword_ff[KEY_W-1:0] : '0;
            ra_in = '0;  rp_in = '0;
         end
         S_LS: begin
            state_in = S_IDLE;  rv_in = 1'b1;
            rs_in = hit_ff ? ST_OK : ST_MISS;
            rk_in = '0;
            ra_in = hit_ff ? hword_ff[SRC_W-1:16] : '0;
            rp_in = hit_ff ? hword_ff[15:0] : '0;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // start a fresh table walk
      if (go) begin
         state_in   = S_SCAN;
         ret_in     = go_ret;
         sel_rev_in = go_rev;
         kcmp_in    = go_key;
         scmp_in    = go_src;
         cnt_in     = '0;
         pv_in      = 1'b0;
         hit_in     = 1'b0;
         frf_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         pv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
         hit_ff   <= 1'b0;
         frf_ff   <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
         rv_ff    <= rv_in;
         hit_ff   <= hit_in;
         frf_ff   <= frf_in;
         full_ff  <= full_in;
      end
      ret_ff     <= ret_in;
      pidx_ff    <= pidx_in;
      sel_rev_ff <= sel_rev_in;
      kcmp_ff    <= kcmp_in;
      scmp_ff    <= scmp_in;
      hidx_ff    <= hidx_in;
      hword_ff   <= hword_in;
      fidx_ff    <= fidx_in;
      save_ff    <= save_in;
      op_ff      <= op_in;
      src_ff     <= src_in;
      key_ff     <= key_in;
      sess_ff    <= sess_in;
      rs_ff      <= rs_in;
      rk_ff      <= rk_in;
      ra_ff      <= ra_in;
      rp_ff      <= rp_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rv_ff;
   assign rsp_status   = rs_ff;
   assign rsp_key_out  = rk_ff;
   assign rsp_addr_out = ra_ff;
   assign rsp_port_out = rp_ff;

   // result strobe only appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   // an accepted word always occupies the sequencer
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word not taken");
   // status code three is never produced
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3)) else $error("bad status");
   // creates and deletes give no data
   a_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (op_ff == REQ_CREATE || op_ff == REQ_DELETE)) |->
      (rsp_key_out == 32'd0 && rsp_addr_out == 32'd0 && rsp_port_out == 16'd0))
      else $error("stray data");
   // clearing pass follows reset
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy) else $error("no clearing pass");
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
module tb_top;
   import bst_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] addr;
      logic [15:0] port;
   } answer_type;

   // scoreboard: owns a copy of both tables and the queue of predicted answers
   class session_scoreboard;
      bit          fv[TABLE_ENTRIES];
      logic [31:0] fk[TABLE_ENTRIES];
      logic [47:0] fs[TABLE_ENTRIES];
      bit          rv[TABLE_ENTRIES];
      logic [47:0] rs[TABLE_ENTRIES];
      logic [31:0] rk[TABLE_ENTRIES];
      answer_type  pending[$];
      int          errors;

      function int fwd_slot(logic [31:0] k);
         for (int i = 0; i < TABLE_ENTRIES; i++) if (fv[i] && fk[i] == k) return i;
         return -1;
      endfunction

      function int rev_slot(logic [47:0] s);
         for (int i = 0; i < TABLE_ENTRIES; i++) if (rv[i] && rs[i] == s) return i;
         return -1;
      endfunction

      function int free_slot(bit is_rev);
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!(is_rev ? rv[i] : fv[i])) return i;
         return -1;
      endfunction

      function void note_request(logic [1:0] rt, logic [31:0] a, logic [15:0] p,
                                 logic [31:0] k, logic [7:0] sn);
         answer_type  ans;
         logic [47:0] src;
         int          f;
         int          r;
         ans = '0;
         ans.status = ST_OK;
         src = {a, p};
         case (rt)
            REQ_CREATE: begin
               f = fwd_slot(k);
               if (f >= 0) begin
                  r = rev_slot(fs[f]);
                  if (r >= 0) rv[r] = 0;
                  fs[f] = src;
               end else begin
                  f = free_slot(0);
                  if (f >= 0) begin
                     fv[f] = 1; fk[f] = k; fs[f] = src;
                  end else ans.status = ST_FULL;
               end
               if (sn > SESSION_LIMIT) begin
                  r = rev_slot(src);
                  if (r >= 0) rk[r] = k;
                  else begin
                     r = free_slot(1);
                     if (r >= 0) begin
                        rv[r] = 1; rs[r] = src; rk[r] = k;
                     end else ans.status = ST_FULL;
                  end
               end
            end
            REQ_DELETE: begin
               r = rev_slot(src);
               if (r >= 0) begin
                  f = fwd_slot(rk[r]);
                  if (f >= 0) fv[f] = 0;
                  rv[r] = 0;
               end else ans.status = ST_MISS;
            end
            REQ_KEY_BY_SRC: begin
               r = rev_slot(src);
               if (r >= 0) ans.key = rk[r];
               else ans.status = ST_MISS;
            end
            default: begin
               f = fwd_slot(k);
               if (f >= 0) begin
                  ans.addr = fs[f][47:16]; ans.port = fs[f][15:0];
               end else ans.status = ST_MISS;
            end
         endcase
         pending.push_back(ans);
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word status=%0d", $time, got.status);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.key !== want.key) begin
            $display("%0t: key_out exp %h got %h", $time, want.key, got.key);
            errors++;
         end
         if (got.addr !== want.addr) begin
            $display("%0t: addr_out exp %h got %h", $time, want.addr, got.addr);
            errors++;
         end
         if (got.port !== want.port) begin
            $display("%0t: port_out exp %h got %h", $time, want.port, got.port);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = REQ_CREATE;
   logic [31:0] req_src_addr = '0;
   logic [15:0] req_src_port = '0;
   logic [31:0] req_key_in = '0;
   logic [7:0]  req_session_num = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_key_out;
   logic [31:0] rsp_addr_out;
   logic [15:0] rsp_port_out;

   bidirectional_session_table_top i_dut (
      .clock, .reset, .start, .busy, .req_type, .req_src_addr, .req_src_port,
      .req_key_in, .req_session_num, .rsp_valid, .rsp_status, .rsp_key_out,
      .rsp_addr_out, .rsp_port_out
   );

   initial begin
      forever #5 clock = ~clock;
   end

   session_scoreboard sb = new();
   int idle_pct = 0;
   int quiet_cycles = 0;
   // longest create plus clearing pass, taken several times over
   localparam int WATCHDOG = 20 * (3 * TABLE_ENTRIES + 9) + 200;

   // small pools of keys and sources so that hits, rewrites and full tables happen
   logic [31:0] key_pool[8];
   logic [47:0] src_pool[8];

   // monitor: a word is accepted at a rising edge with start high and busy low
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_answer({rsp_status, rsp_key_out, rsp_addr_out, rsp_port_out});
      if (!reset && start && !busy)
         sb.note_request(req_type, req_src_addr, req_src_port, req_key_in,
                         req_session_num);
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // offer one word, hold it until taken; random gaps in front
   // start stays high after the take, the block is busy then and ignores it
   task automatic send_word(logic [1:0] rt, logic [31:0] a, logic [15:0] p,
                            logic [31:0] k, logic [7:0] sn);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_type <= rt; req_src_addr <= a; req_src_port <= p;
      req_key_in <= k; req_session_num <= sn;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_word();
      logic [47:0] s;
      logic [31:0] k;
      s = src_pool[$urandom_range(7)];
      k = key_pool[$urandom_range(7)];
      // mostly pooled values, some fresh noise to fill and miss
      if ($urandom_range(3) == 0) s = {$urandom(), 16'($urandom())};
      if ($urandom_range(3) == 0) k = $urandom();
      send_word(2'($urandom()), s[47:16], s[15:0], k, 8'($urandom()));
   endtask

   task automatic drain();
      start <= 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) begin
         key_pool[i] = $urandom();
         src_pool[i] = {$urandom(), 16'($urandom())};
      end
      key_pool[0] = '0; key_pool[1] = '1;
      src_pool[0] = '0; src_pool[1] = '1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: misses on empty tables, extremes, create with and without reverse
      send_word(REQ_KEY_BY_SRC, '0, '0, '0, '0);
      send_word(REQ_SRC_BY_KEY, '1, '1, '1, '1);
      send_word(REQ_DELETE, '1, '1, '0, '0);
      send_word(REQ_CREATE, '1, '1, '1, 8'd128);
      send_word(REQ_CREATE, '0, '0, '0, 8'd127);
      send_word(REQ_SRC_BY_KEY, '0, '0, '1, '0);
      send_word(REQ_KEY_BY_SRC, '1, '1, '0, '0);
      send_word(REQ_KEY_BY_SRC, '0, '0, '0, '0);
      // re-point an existing key to a new source, old reverse entry goes away
      send_word(REQ_CREATE, 32'h1234_5678, 16'hABCD, '1, 8'd255);
      send_word(REQ_KEY_BY_SRC, '1, '1, '0, '0);
      send_word(REQ_DELETE, 32'h1234_5678, 16'hABCD, '0, '0);
      send_word(REQ_SRC_BY_KEY, '0, '0, '1, '0);
      // fill both tables past capacity
      for (int i = 0; i < TABLE_ENTRIES + 2; i++)
         send_word(REQ_CREATE, 32'(i) + 32'h100, 16'(i), 32'(i) + 32'h5000, 8'd200);
      drain();
      for (int i = 0; i < TABLE_ENTRIES + 2; i++)
         send_word(REQ_DELETE, 32'(i) + 32'h100, 16'(i), '0, '0);
      drain();

      // random phases with varying sender idling
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 79 : (ph == 3) ? 30 : 0;
         for (int n = 0; n < 175; n++) random_word();
         drain();
      end
      repeat (3 * TABLE_ENTRIES + 20) @(negedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
